@@ design/imcg_pkg.sv @@
// Package for the interval merge block: sequencer state type.
// Used by the top level, interval_merge_coverage_gap.
`timescale 1ns / 1ps
package imcg_pkg;
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FIN_I,
        ST_FIN_J,
        ST_OUT
    } state_t;
endpackage

@@ design/interval_merge_coverage_gap.sv @@
// Interval merge with longest busy span and longest idle gap.
// Depends on imcg_pkg and imcg_ram.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_ready, op, span_*            | into block
//  out     | out_valid, out_ready, longest_*, overflow | out of block
//
// An add is accepted in ST_IDLE and then makes a sweep (one read per slot,
// registered read data and a drain) and one write of the merged interval.
// A finish visits each slot in turn and makes a sweep for each valid slot,
// then presents the result.
// Reset clears the valid bits and the overflow flag; no clearing pass.
// A result waits in the output register while out_ready is low; the next
// item is taken once the result is delivered.
`timescale 1ns / 1ps
module interval_merge_coverage_gap
    import imcg_pkg::*;
#(
    parameter int MAX_SPANS  = 64,
    parameter int TIME_WIDTH = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [TIME_WIDTH-1:0] span_start,
    input  logic [TIME_WIDTH-1:0] span_stop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TIME_WIDTH-1:0] longest_busy,
    output logic [TIME_WIDTH-1:0] longest_idle,
    output logic                  overflow
);
    localparam int AW = $clog2(MAX_SPANS);
    localparam int CW = AW + 1;

    state_t state_reg, state_next;
    logic [MAX_SPANS-1:0] valid_reg;
    logic                 ovf_reg;
    logic [CW-1:0]        cnt_reg;      // read address counter
    logic                 rv_reg;       // read data valid this cycle
    logic [AW-1:0]        radr_reg;     // address of data arriving
    logic [AW-1:0]        i_reg;
    logic [TIME_WIDTH-1:0] lo_reg, hi_reg, busy_reg, idle_reg;
    logic [TIME_WIDTH-1:0] is_reg, ie_reg;   // slot i begin and end
    logic [TIME_WIDTH-1:0] ns_reg;           // best successor begin
    logic                 nf_reg;           // successor found
    logic                 ild_reg;          // slot i data loaded

    logic [AW-1:0]         raddr;
    logic [TIME_WIDTH-1:0] rs, re;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         free_idx;
    logic                  free_any;
    logic                  scan_done;

    imcg_ram #(.WIDTH(TIME_WIDTH), .DEPTH(MAX_SPANS)) u_start (
        .clk(clk), .we(we), .waddr(waddr), .wdata(lo_reg),
        .raddr(raddr), .rdata(rs));
    imcg_ram #(.WIDTH(TIME_WIDTH), .DEPTH(MAX_SPANS)) u_stop (
        .clk(clk), .we(we), .waddr(waddr), .wdata(hi_reg),
        .raddr(raddr), .rdata(re));

    // Slot i is read while in ST_FIN_I so that it is known before the sweep.
    assign raddr = (state_reg == ST_FIN_I) ? i_reg : cnt_reg[AW-1:0];
    assign we    = (state_reg == ST_WRITE) && free_any;
    assign waddr = free_idx;
    assign scan_done = (cnt_reg == CW'(MAX_SPANS)) && !rv_reg;

    // Lowest free slot, priority encoded.
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int k = MAX_SPANS - 1; k >= 0; k--)
        begin
            if (!valid_reg[k])
            begin
                free_idx = AW'(k);
                free_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = op ? ST_FIN_I : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_FIN_I:
            begin
                if (valid_reg[i_reg])
                begin
                    state_next = ST_FIN_J;
                end
                else if (i_reg == AW'(MAX_SPANS - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_FIN_J:
            begin
                if (scan_done)
                begin
                    state_next = (i_reg == AW'(MAX_SPANS - 1)) ? ST_OUT : ST_FIN_I;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
    end

    assign longest_busy = busy_reg;
    assign longest_idle = idle_reg;
    assign overflow     = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            ovf_reg   <= 1'b0;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    i_reg   <= '0;
                end
                ST_SCAN, ST_FIN_J:
                begin
                    if (cnt_reg != CW'(MAX_SPANS))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        rv_reg  <= 1'b1;
                    end
                    if (rv_reg && state_reg == ST_SCAN && valid_reg[radr_reg]
                        && !(hi_reg < rs || lo_reg > re))
                    begin
                        valid_reg[radr_reg] <= 1'b0;
                    end
                    if (scan_done && state_reg == ST_FIN_J)
                    begin
                        i_reg   <= i_reg + 1'b1;
                        cnt_reg <= '0;
                    end
                end
                ST_WRITE:
                begin
                    if (free_any)
                    begin
                        valid_reg[free_idx] <= 1'b1;
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                ST_FIN_I:
                begin
                    cnt_reg <= '0;
                    if (!valid_reg[i_reg])
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        valid_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        radr_reg <= raddr;
        case (state_reg)
            ST_IDLE:
            begin
                if (span_start > span_stop)
                begin
                    lo_reg <= span_stop;
                    hi_reg <= span_start;
                end
                else
                begin
                    lo_reg <= span_start;
                    hi_reg <= span_stop;
                end
                busy_reg <= '0;
                idle_reg <= '0;
            end
            ST_SCAN:
            begin
                if (rv_reg && valid_reg[radr_reg] && !(hi_reg < rs || lo_reg > re))
                begin
                    if (rs < lo_reg)
                    begin
                        lo_reg <= rs;
                    end
                    if (re > hi_reg)
                    begin
                        hi_reg <= re;
                    end
                end
            end
            ST_FIN_I:
            begin
                nf_reg  <= 1'b0;
                ild_reg <= 1'b0;
            end
            ST_FIN_J:
            begin
                // The first cycle of the sweep carries slot i, read in ST_FIN_I.
                if (!ild_reg)
                begin
                    is_reg  <= rs;
                    ie_reg  <= re;
                    ild_reg <= 1'b1;
                    if (re - rs > busy_reg)
                    begin
                        busy_reg <= re - rs;
                    end
                end
                if (rv_reg && valid_reg[radr_reg] && radr_reg != i_reg
                    && rs > is_reg && (!nf_reg || rs < ns_reg))
                begin
                    ns_reg <= rs;
                    nf_reg <= 1'b1;
                end
                if (scan_done && nf_reg && ns_reg > ie_reg
                    && ns_reg - ie_reg > idle_reg)
                begin
                    idle_reg <= ns_reg - ie_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(longest_busy))
        else $error("result changed while stalled");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ovf_reg) |-> ovf_reg)
        else $error("overflow flag cleared");
`endif
endmodule

@@ design/imcg_ram.sv @@
// Generic single-port write, single-port read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module imcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
